// ----- design/glos_pkg.sv -----
// shared types and constants for the grid line-of-sight checker
// no dependencies; imported by every module of the block
package glos_pkg;

  localparam int DEF_COORD_BITS     = 8;
  localparam int DEF_CLEARANCE_BITS = 8;
  localparam int DEF_FRAC_BITS      = 16;

  // fraction bits of the line length, fixed by the Q.8 length format
  localparam int LEN_FRAC = 8;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 9;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_CLEARANCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT   = 2'd2;

  localparam logic [8:0] GRID_DIM_RESET = 9'd256;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQRT,
    S_SQRT_WAIT,
    S_DIVX,
    S_DIVX_WAIT,
    S_DIVY,
    S_DIVY_WAIT,
    S_WALK,
    S_CHECK,
    S_DONE
  } glos_state_t;

  typedef enum logic {
    MODE_DIV,
    MODE_SQRT
  } unit_mode_t;

  typedef struct packed {
    logic       go;
    unit_mode_t mode;
  } unit_ctl_t;

endpackage

// ----- design/grid_line_of_sight_check.sv -----
// grid line-of-sight checker, top level: config registers, sequencer, ray walk
// depends on glos_pkg, glos_shift_sub, glos_grid_mem
//
// A load word (operation 0) writes one clearance cell in the cycle it is taken
// and busy never rises. A query word (operation 1) holds busy while one shared
// shift-subtract unit forms the line length and the two step components; the
// walk then steps along the ray, with an extra check state for each newly
// entered cell because of the registered store read. The map is 256 by 256
// cells after reset. The answer appears on reachable and left_map for exactly
// one cycle with done high; the receiver cannot stall it. Reads of cells never
// loaded give undefined results.
module grid_line_of_sight_check
  import glos_pkg::*;
#(
  parameter int COORD_BITS     = DEF_COORD_BITS,
  parameter int CLEARANCE_BITS = DEF_CLEARANCE_BITS,
  parameter int FRAC_BITS      = DEF_FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic                 operation,
  input  logic [7:0]           load_x,
  input  logic [7:0]           load_y,
  input  logic [7:0]           load_clearance,
  input  logic [7:0]           from_x,
  input  logic [7:0]           from_y,
  input  logic [7:0]           to_x,
  input  logic [7:0]           to_y,
  output logic                 done,
  output logic                 reachable,
  output logic                 left_map,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);
  import glos_pkg::*;

  localparam int PW   = COORD_BITS + FRAC_BITS;
  localparam int SQW  = 2 * COORD_BITS + 1;
  localparam int SW   = 2 * COORD_BITS + 2 * LEN_FRAC + 2;
  localparam int LW   = COORD_BITS + LEN_FRAC + 1;
  localparam int DW   = COORD_BITS + FRAC_BITS + LEN_FRAC + 1;
  localparam int XW   = (SW > DW) ? SW : DW;
  localparam int RW   = COORD_BITS + LEN_FRAC + 4;
  localparam int MW   = FRAC_BITS + 1;
  localparam int CNTW = $clog2(XW + 1);
  localparam int AW   = 2 * COORD_BITS;
  localparam int KW   = (CLEARANCE_BITS > 8) ? CLEARANCE_BITS : 8;

  glos_state_t state, state_next;

  logic [7:0] min_clearance;
  logic [8:0] grid_width;
  logic [8:0] grid_height;

  logic [COORD_BITS-1:0] tx, ty, adx, ady, lastx, lasty, cx, cy;
  logic                  sx, sy, first;
  logic [LW-1:0]         len;
  logic [MW-1:0]         magx, magy, mag_c;
  logic [PW-1:0]         posx, posy, posx_step, posy_step;
  logic                  res_reach, res_left;

  logic [COORD_BITS-1:0] fx_in, fy_in, tx_in, ty_in;
  logic [SQW-1:0]        sq;
  logic [DW-1:0]         dvd;
  logic [COORD_BITS-1:0] mag_d;

  unit_ctl_t             u_ctl;
  logic [XW-1:0]         u_operand, u_result;
  logic [CNTW-1:0]       u_steps;
  logic                  u_done;

  logic                  mem_we;
  logic [CLEARANCE_BITS-1:0] rd_data;

  logic accept, at_end, new_cell, off_map, blocked;

  assign accept = start && (state == S_IDLE);
  assign cfg_ready = 1'b1;

  assign fx_in = COORD_BITS'(from_x);
  assign fy_in = COORD_BITS'(from_y);
  assign tx_in = COORD_BITS'(to_x);
  assign ty_in = COORD_BITS'(to_y);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_clearance <= '0;
      grid_width    <= GRID_DIM_RESET;
      grid_height   <= GRID_DIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MIN_CLEARANCE: min_clearance <= cfg_data[7:0];
        REG_GRID_WIDTH:    grid_width    <= cfg_data;
        REG_GRID_HEIGHT:   grid_height   <= cfg_data;
        default: ;
      endcase
    end
  end

  // operands for the shared unit
  always_comb begin
    sq    = SQW'(adx) * SQW'(adx) + SQW'(ady) * SQW'(ady);
    mag_d = (state == S_DIVY) ? ady : adx;
    dvd   = (DW'(mag_d) << (FRAC_BITS + LEN_FRAC)) + DW'(len >> 1);
    if (state == S_SQRT) begin
      // sum of squares scaled by 2^(2*LEN_FRAC), padded to an even width
      u_operand = XW'({1'b0, sq, {(2 * LEN_FRAC){1'b0}}}) << (XW - SW);
      u_steps   = CNTW'(SW / 2);
    end else begin
      u_operand = XW'(dvd) << (XW - DW);
      u_steps   = CNTW'(DW);
    end
  end

  // round-half-up quotient clamped to [one LSB, 1.0]
  always_comb begin
    if (u_result == '0) begin
      mag_c = MW'(1);
    end else if (u_result > (XW'(1) << FRAC_BITS)) begin
      mag_c = MW'(1) << FRAC_BITS;
    end else begin
      mag_c = MW'(u_result);
    end
  end

  // walk decisions
  always_comb begin
    cx        = posx[PW-1:FRAC_BITS];
    cy        = posy[PW-1:FRAC_BITS];
    at_end    = !first && (lastx == tx) && (lasty == ty);
    new_cell  = first || (cx != lastx) || (cy != lasty);
    off_map   = (16'(cx) >= 16'(grid_width)) || (16'(cy) >= 16'(grid_height));
    blocked   = KW'(rd_data) < KW'(min_clearance);
    posx_step = sx ? (posx - PW'(magx)) : (posx + PW'(magx));
    posy_step = sy ? (posy - PW'(magy)) : (posy + PW'(magy));
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:      if (start && operation == OP_QUERY) state_next = S_SQRT;
      S_SQRT:      state_next = S_SQRT_WAIT;
      S_SQRT_WAIT: if (u_done) state_next = S_DIVX;
      S_DIVX:      state_next = S_DIVX_WAIT;
      S_DIVX_WAIT: if (u_done) state_next = S_DIVY;
      S_DIVY:      state_next = S_DIVY_WAIT;
      S_DIVY_WAIT: if (u_done) state_next = S_WALK;
      S_WALK: begin
        if (at_end) begin
          state_next = S_DONE;
        end else if (new_cell) begin
          state_next = off_map ? S_DONE : S_CHECK;
        end
      end
      S_CHECK:     state_next = blocked ? S_DONE : S_WALK;
      S_DONE:      state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    u_ctl.go   = 1'b0;
    u_ctl.mode = MODE_DIV;
    mem_we     = 1'b0;
    busy       = 1'b1;
    done       = 1'b0;
    case (state)
      S_IDLE: begin
        busy   = 1'b0;
        mem_we = start && (operation == OP_LOAD);
      end
      S_SQRT: begin
        u_ctl.go   = 1'b1;
        u_ctl.mode = MODE_SQRT;
      end
      S_DIVX, S_DIVY: u_ctl.go = 1'b1;
      S_DONE: done = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          tx    <= tx_in;
          ty    <= ty_in;
          sx    <= tx_in < fx_in;
          sy    <= ty_in < fy_in;
          adx   <= (tx_in < fx_in) ? (fx_in - tx_in) : (tx_in - fx_in);
          ady   <= (ty_in < fy_in) ? (fy_in - ty_in) : (ty_in - fy_in);
          posx  <= {fx_in, {FRAC_BITS{1'b0}}};
          posy  <= {fy_in, {FRAC_BITS{1'b0}}};
          first <= 1'b1;
        end
      end
      S_SQRT_WAIT: if (u_done) len <= LW'(u_result);
      S_DIVX_WAIT: if (u_done) magx <= (adx == '0) ? '0 : mag_c;
      S_DIVY_WAIT: if (u_done) magy <= (ady == '0) ? '0 : mag_c;
      S_WALK: begin
        if (at_end) begin
          res_reach <= 1'b1;
          res_left  <= 1'b0;
        end else if (new_cell) begin
          lastx <= cx;
          lasty <= cy;
          first <= 1'b0;
          if (off_map) begin
            res_reach <= 1'b0;
            res_left  <= 1'b1;
          end
        end else begin
          if (lastx != tx) posx <= posx_step;
          if (lasty != ty) posy <= posy_step;
        end
      end
      S_CHECK: begin
        if (blocked) begin
          res_reach <= 1'b0;
          res_left  <= 1'b0;
        end else begin
          if (lastx != tx) posx <= posx_step;
          if (lasty != ty) posy <= posy_step;
        end
      end
      default: ;
    endcase
  end

  assign reachable = res_reach;
  assign left_map  = res_left;

  glos_shift_sub #(
    .XW   (XW),
    .RW   (RW),
    .CNTW (CNTW)
  ) u_unit (
    .clk     (clk),
    .rst     (rst),
    .ctl     (u_ctl),
    .operand (u_operand),
    .divisor (RW'(len)),
    .steps   (u_steps),
    .done    (u_done),
    .result  (u_result)
  );

  glos_grid_mem #(
    .AW (AW),
    .DW (CLEARANCE_BITS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr ({COORD_BITS'(load_y), COORD_BITS'(load_x)}),
    .wdata (CLEARANCE_BITS'(load_clearance)),
    .raddr ({cy, cx}),
    .rdata (rd_data)
  );

endmodule

// ----- design/glos_shift_sub.sv -----
// shared shift-subtract unit: restoring divide or bit-pair square root
// depends on glos_pkg; one result digit per cycle
module glos_shift_sub #(
  parameter int XW = 33,
  parameter int RW = 20,
  parameter int CNTW = 6
) (
  input  logic                 clk,
  input  logic                 rst,
  input  glos_pkg::unit_ctl_t  ctl,
  input  logic [XW-1:0]        operand,
  input  logic [RW-1:0]        divisor,
  input  logic [CNTW-1:0]      steps,
  output logic                 done,
  output logic [XW-1:0]        result
);
  import glos_pkg::*;

  logic            active;
  logic            sq_mode;
  logic [CNTW-1:0] cnt;
  logic [XW-1:0]   x;
  logic [XW-1:0]   q;
  logic [RW-1:0]   rem;
  logic [RW-1:0]   cand;
  logic [RW-1:0]   sub;
  logic            ge;

  always_comb begin
    if (sq_mode) begin
      cand = {rem[RW-3:0], x[XW-1:XW-2]};
      sub  = {q[RW-3:0], 2'b01};
    end else begin
      cand = {rem[RW-2:0], x[XW-1]};
      sub  = divisor;
    end
    ge = (cand >= sub);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.go) begin
        active <= 1'b1;
        cnt    <= steps;
      end else if (active) begin
        cnt <= cnt - CNTW'(1);
        if (cnt == CNTW'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.go) begin
      sq_mode <= (ctl.mode == MODE_SQRT);
      x       <= operand;
      q       <= '0;
      rem     <= '0;
    end else if (active) begin
      x   <= sq_mode ? (x << 2) : (x << 1);
      rem <= ge ? (cand - sub) : cand;
      q   <= {q[XW-2:0], ge};
    end
  end

  assign result = q;

endmodule

// ----- design/glos_grid_mem.sv -----
// clearance store: one write port, one registered read port
// depends on glos_pkg for nothing but house style
module glos_grid_mem #(
  parameter int AW = 16,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);
  import glos_pkg::*;

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- design/glos_checker.sv -----
// port-level checks for the grid line-of-sight checker
// depends on glos_pkg; bound to grid_line_of_sight_check below
module glos_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic operation,
  input logic done,
  input logic reachable,
  input logic left_map
);
  import glos_pkg::*;

  // a result word lasts one cycle
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held for more than one cycle");

  a_one_reason: assert property (@(posedge clk) disable iff (rst)
      done |-> !(reachable && left_map))
    else $error("reachable and left_map both set");

  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result shown while idle");

  // a query ends only through a result word
  a_end_query: assert property (@(posedge clk) disable iff (rst)
      $fell(busy) |-> $past(done))
    else $error("busy dropped without a result");

  // a load word never occupies the block
  a_load_fast: assert property (@(posedge clk) disable iff (rst)
      (start && !busy && operation == OP_LOAD) |=> !busy)
    else $error("load word made the block busy");

endmodule

bind grid_line_of_sight_check glos_checker u_glos_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .operation (operation),
  .done      (done),
  .reachable (reachable),
  .left_map  (left_map)
);

// ----- dv/tb_grid_line_of_sight_check.sv -----
// self-checking testbench for grid_line_of_sight_check: directed table, then random phases
// depends on glos_pkg and the block's rtl; typed rows or a ray-walk model give expectations
module tb_grid_line_of_sight_check;
  import glos_pkg::*;

  typedef enum int {ROW_CFG, ROW_LOAD, ROW_QUERY} row_kind_t;

  typedef struct {
    row_kind_t kind;
    int        a, b, c, d;   // cfg: index,data  load: x,y,clr  query: fx,fy,tx,ty
    bit        typed;
    bit        t_reach, t_left;
  } stim_row_t;

  typedef struct {
    bit reach;
    bit left;
  } answer_t;

  // random queries stay in a small corner so loaded cells get reused
  localparam int RSPAN = 20;
  // minimum total of words sent, loads and queries alike
  localparam int ITEMS = 1070;

  logic clk = 0, rst = 1;
  logic start = 0, operation = OP_LOAD;
  logic [7:0] load_x = 0, load_y = 0, load_clearance = 0;
  logic [7:0] from_x = 0, from_y = 0, to_x = 0, to_y = 0;
  logic cfg_valid = 0;
  logic [CFG_IDX_W-1:0] cfg_index = 0;
  logic [CFG_DATA_W-1:0] cfg_data = 0;
  logic busy, done, reachable, left_map, cfg_ready;

  grid_line_of_sight_check uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .operation(operation),
    .load_x(load_x), .load_y(load_y), .load_clearance(load_clearance),
    .from_x(from_x), .from_y(from_y), .to_x(to_x), .to_y(to_y),
    .done(done), .reachable(reachable), .left_map(left_map),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  initial begin
    #80_000_000;
    $display("timeout waiting for the block");
    $display("RESULT: ERROR");
    $finish;
  end

  // predictor state
  bit [7:0] clr_cells [65536];
  bit       cell_loaded [65536];
  int       min_clr = 0, width = 256, height = 256;
  answer_t  pending_answers [$];
  int       errors = 0, mismatches = 0, n_queries = 0, n_loads = 0, n_blocked = 0;
  int       n_offmap = 0, gap_pct = 0;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= r + bitv) begin
        v = v - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    return r;
  endfunction

  function automatic longint unit_step(longint d, longint unsigned len);
    longint unsigned mag;
    if (d == 0 || len == 0) return 0;
    mag = (d < 0) ? -d : d;
    mag = ((mag << 24) + len / 2) / len;
    if (mag < 1) mag = 1;
    if (mag > 65536) mag = 65536;
    return (d < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  // walks the ray; miss is the first visited cell never loaded, or -1
  function automatic void ray_walk(input int fx, fy, tx, ty, output answer_t ans,
                                   output int miss);
    longint dx, dy, sx, sy, px, py;
    longint unsigned len;
    int lx, ly, cx, cy, guard;
    dx = tx - fx;
    dy = ty - fy;
    len = int_sqrt(longint'(dx * dx + dy * dy) << 16);
    sx = unit_step(dx, len);
    sy = unit_step(dy, len);
    px = longint'(fx) << 16;
    py = longint'(fy) << 16;
    lx = -1;
    ly = -1;
    ans.reach = 1;
    ans.left = 0;
    miss = -1;
    guard = 0;
    while (lx != tx || ly != ty) begin
      cx = int'((px >> 16) & 16'hFFFF);
      cy = int'((py >> 16) & 16'hFFFF);
      if (cx != lx || cy != ly) begin
        lx = cx;
        ly = cy;
        if (cx >= width || cy >= height) begin
          ans.reach = 0;
          ans.left = 1;
          return;
        end
        if (!cell_loaded[(cy & 255) * 256 + (cx & 255)]) begin
          miss = (cy & 255) * 256 + (cx & 255);
          return;
        end
        if (clr_cells[(cy & 255) * 256 + (cx & 255)] < min_clr) begin
          ans.reach = 0;
          return;
        end
      end
      if (lx != tx) px += sx;
      if (ly != ty) py += sy;
      guard++;
      if (guard > (1 << 26)) begin
        ans.reach = 0;
        return;
      end
    end
  endfunction

  task automatic send_word(bit op, int a, b, c, d);
    @(negedge clk);
    start = 1;
    operation = op;
    if (op == OP_LOAD) begin
      load_x = 8'(a); load_y = 8'(b); load_clearance = 8'(c);
      from_x = 8'($urandom); from_y = 8'($urandom);
      to_x = 8'($urandom); to_y = 8'($urandom);
    end else begin
      from_x = 8'(a); from_y = 8'(b); to_x = 8'(c); to_y = 8'(d);
      load_x = 8'($urandom); load_y = 8'($urandom); load_clearance = 8'($urandom);
    end
    do @(posedge clk); while (busy);
    if ($urandom_range(99) < gap_pct) begin
      @(negedge clk);
      start = 0;
      repeat ($urandom_range(6)) @(negedge clk);
    end
  endtask

  task automatic load_cell(int x, y, clr);
    send_word(OP_LOAD, x, y, clr, 0);
    clr_cells[y * 256 + x] = clr;
    cell_loaded[y * 256 + x] = 1;
    n_loads++;
  endtask

  // loads every cell the ray would read that was never written, then sends the query
  task automatic query_line(int fx, fy, tx, ty, bit typed, bit t_reach, bit t_left);
    answer_t ans;
    int miss;
    forever begin
      ray_walk(fx, fy, tx, ty, ans, miss);
      if (miss < 0) break;
      load_cell(miss % 256, miss / 256,
                ($urandom_range(99) < 85) ? $urandom_range(255, min_clr) : $urandom_range(255));
    end
    if (typed) begin
      ans.reach = t_reach;
      ans.left = t_left;
    end
    pending_answers.push_back(ans);
    send_word(OP_QUERY, fx, fy, tx, ty);
    n_queries++;
    if (ans.left) n_offmap++;
    else if (!ans.reach) n_blocked++;
  endtask

  task automatic drain();
    @(negedge clk);
    start = 0;
    while (pending_answers.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(int idx, int val);
    drain();
    @(negedge clk);
    cfg_valid = 1;
    cfg_index = CFG_IDX_W'(idx);
    cfg_data = CFG_DATA_W'(val);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 0;
    case (idx)
      REG_MIN_CLEARANCE: min_clr = val & 8'hFF;
      REG_GRID_WIDTH:    width = val & 9'h1FF;
      REG_GRID_HEIGHT:   height = val & 9'h1FF;
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_answers.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("unexpected result word reach=%0b left=%0b",
                                         reachable, left_map);
      end else begin
        answer_t e;
        e = pending_answers.pop_front();
        if (reachable !== e.reach || left_map !== e.left) begin
          errors++;
          if (mismatches++ < 10)
            $display("mismatch: expected reach=%0b left=%0b, got reach=%0b left=%0b",
                     e.reach, e.left, reachable, left_map);
        end
      end
    end
  end

  stim_row_t directed [] = '{
    '{ROW_LOAD, 0, 0, 255, 0, 0, 0, 0},
    '{ROW_LOAD, 255, 255, 0, 0, 0, 0, 0},
    '{ROW_QUERY, 0, 0, 0, 0, 1, 1, 0},
    '{ROW_QUERY, 255, 255, 255, 255, 1, 1, 0},
    '{ROW_CFG, REG_MIN_CLEARANCE, 1, 0, 0, 0, 0, 0},
    '{ROW_QUERY, 255, 255, 255, 255, 1, 0, 0},
    '{ROW_QUERY, 0, 0, 0, 0, 1, 1, 0},
    '{ROW_CFG, REG_GRID_WIDTH, 1, 0, 0, 0, 0, 0},
    '{ROW_QUERY, 0, 0, 0, 0, 1, 1, 0},
    '{ROW_QUERY, 255, 255, 255, 255, 1, 0, 1},
    '{ROW_QUERY, 0, 0, 5, 0, 1, 0, 1},
    '{ROW_CFG, REG_GRID_WIDTH, 0, 0, 0, 0, 0, 0},
    '{ROW_QUERY, 0, 0, 0, 0, 1, 0, 1},
    '{ROW_CFG, REG_GRID_WIDTH, 256, 0, 0, 0, 0, 0},
    '{ROW_CFG, REG_GRID_HEIGHT, 0, 0, 0, 0, 0, 0},
    '{ROW_QUERY, 0, 0, 0, 0, 1, 0, 1},
    '{ROW_CFG, REG_GRID_HEIGHT, 256, 0, 0, 0, 0, 0},
    '{ROW_CFG, 3, 511, 0, 0, 0, 0, 0},
    '{ROW_CFG, REG_MIN_CLEARANCE, 255, 0, 0, 0, 0, 0},
    '{ROW_QUERY, 0, 0, 255, 255, 0, 0, 0},
    '{ROW_QUERY, 255, 0, 0, 255, 0, 0, 0},
    '{ROW_CFG, REG_MIN_CLEARANCE, 0, 0, 0, 0, 0, 0},
    '{ROW_QUERY, 255, 255, 0, 0, 0, 0, 0},
    '{ROW_QUERY, 10, 40, 13, 3, 0, 0, 0}
  };

  initial begin
    int fx, fy, tx, ty, base, quota;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 0;

    foreach (directed[i]) begin
      case (directed[i].kind)
        ROW_CFG:  write_reg(directed[i].a, directed[i].b);
        ROW_LOAD: load_cell(directed[i].a, directed[i].b, directed[i].c);
        default:  query_line(directed[i].a, directed[i].b, directed[i].c, directed[i].d,
                             directed[i].typed, directed[i].t_reach, directed[i].t_left);
      endcase
    end

    base = n_loads + n_queries;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: gap_pct = 0;
        1: gap_pct = 55;
        2: gap_pct = 0;
        default: gap_pct = 25;
      endcase
      write_reg(REG_MIN_CLEARANCE, (phase == 7) ? 255 : (phase == 0) ? 0 : $urandom_range(200));
      write_reg(REG_GRID_WIDTH, (phase % 3 == 0) ? 256 : (phase == 5) ? 1 :
                $urandom_range(RSPAN + 8, 1));
      write_reg(REG_GRID_HEIGHT, (phase % 3 == 1) ? 256 : $urandom_range(RSPAN + 8, 1));
      quota = base + ((base < ITEMS) ? ((ITEMS - base) * (phase + 1)) / 8 : 0);
      while (n_loads + n_queries < quota) begin
        if ($urandom_range(99) < 15) begin
          load_cell($urandom_range(RSPAN - 1), $urandom_range(RSPAN - 1), $urandom_range(255));
        end else begin
          fx = $urandom_range(RSPAN - 1);
          fy = $urandom_range(RSPAN - 1);
          if ($urandom_range(99) < 10) begin
            tx = $urandom_range(RSPAN - 1);
            ty = $urandom_range(RSPAN - 1);
          end else begin
            tx = fx + int'($urandom_range(12)) - 6;
            ty = fy + int'($urandom_range(12)) - 6;
            if (tx < 0) tx = 0;
            if (tx > RSPAN - 1) tx = RSPAN - 1;
            if (ty < 0) ty = 0;
            if (ty > RSPAN - 1) ty = RSPAN - 1;
          end
          query_line(fx, fy, tx, ty, 0, 0, 0);
        end
      end
    end

    drain();
    repeat (20) @(posedge clk);
    $display("%0d queries (%0d blocked, %0d off map) and %0d cell loads over 8 config phases",
             n_queries, n_blocked, n_offmap, n_loads);
    $display("%0d mismatching or unexpected result words", errors);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- grid_line_of_sight_check.f -----
design/glos_pkg.sv
design/glos_shift_sub.sv
design/glos_grid_mem.sv
design/grid_line_of_sight_check.sv
design/glos_checker.sv
dv/tb_grid_line_of_sight_check.sv
